>>> src/euler_xyz_to_rotation_matrix_top_macros.svh
// Assertion macros for the Euler XYZ rotation matrix block.
// Used by the top level only; holds no logic of its own.
`ifndef EULER_XYZ_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define EULER_XYZ_TO_ROTATION_MATRIX_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define EXR_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define EXR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

>>> src/exr_pkg.sv
// Package for the Euler XYZ rotation matrix block.
// Holds widths, stage count, CORDIC constants, arctangent table, math helpers.
package exr_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_W = 16;
  localparam int OUT_W = 16;
  localparam int CW = 34;
  localparam int PW = 2 * CW;
  localparam int MUL_DEPTH = 3;
  localparam int LAT = CORDIC_STAGES + 1 + MUL_DEPTH;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [CW-1:0] atan_phase(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q4.30 product rounded half up.
  function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
    return CW'(p >>> 30);
  endfunction

  // Q6.30 sum to saturated Q1.15.
  function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] r;
    r = (v + (CW+2)'(16384)) >>> 15;
    if (r > 32767) return 16'sd32767;
    if (r < -32768) return -16'sd32768;
    return OUT_W'(r);
  endfunction
endpackage

>>> src/euler_xyz_to_rotation_matrix_top.sv
// Euler XYZ angles to 3x3 rotation matrix Rx*Ry*Rz in Q1.15.
// Input transfers pass the CORDIC stages, the lane output registers and the
// merge stages; throughput one transfer per cycle unless the output stalls.
// The pipeline advances whenever its last stage is empty or being taken, so a
// stalled output freezes every stage. Synchronous active-high reset clears
// the valid bits only.
`include "euler_xyz_to_rotation_matrix_top_macros.svh"
module euler_xyz_to_rotation_matrix_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [exr_pkg::ANGLE_W-1:0] angle_x,
  input  logic signed [exr_pkg::ANGLE_W-1:0] angle_y,
  input  logic signed [exr_pkg::ANGLE_W-1:0] angle_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [exr_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22
);
  import exr_pkg::*;
  // One valid bit per pipeline stage; the last one is the output register.
  logic [LAT-1:0] vld;
  logic adv;
  logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [OUT_W-1:0] m [9];

  assign adv = !vld[LAT-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Three lanes, one per axis.
  exr_cordic u_lx (.clk, .en(adv), .angle(angle_x), .sin_o(sx), .cos_o(cx));
  exr_cordic u_ly (.clk, .en(adv), .angle(angle_y), .sin_o(sy), .cos_o(cy));
  exr_cordic u_lz (.clk, .en(adv), .angle(angle_z), .sin_o(sz), .cos_o(cz));

  exr_merge u_merge (.clk, .en(adv), .sx, .cx, .sy, .cy, .sz, .cz, .m);

  assign m00 = m[0]; assign m01 = m[1]; assign m02 = m[2];
  assign m10 = m[3]; assign m11 = m[4]; assign m12 = m[5];
  assign m20 = m[6]; assign m21 = m[7]; assign m22 = m[8];

  `EXR_ASSERT_IMP(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `EXR_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(m00))
  `EXR_ASSERT_NEXT(a_no_accept_empty, clk, rst, !(in_valid && in_ready) && !(|vld[LAT-2:0]),
                   !(|vld[LAT-2:1]) || !$past(adv))
endmodule

>>> src/exr_cordic.sv
// Pipelined rotation-mode CORDIC lane giving sine and cosine of one angle.
// Depends on exr_pkg; one stage per iteration, enabled by the pipeline advance.
module exr_cordic (
  input  logic clk,
  input  logic en,
  input  logic signed [exr_pkg::ANGLE_W-1:0] angle,
  output logic signed [exr_pkg::CW-1:0] sin_o,
  output logic signed [exr_pkg::CW-1:0] cos_o
);
  import exr_pkg::*;
  // Element k holds the output of stage k.
  logic signed [CW-1:0] x [CORDIC_STAGES];
  logic signed [CW-1:0] y [CORDIC_STAGES];
  logic signed [CW-1:0] z [CORDIC_STAGES];
  logic flip [CORDIC_STAGES];
  logic [31:0] ph;
  logic fl;
  logic signed [CW-1:0] z0;

  always_comb begin
    ph = {angle, 16'h0000};
    fl = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (fl) ph = ph - 32'h8000_0000;
    z0 = CW'($signed(ph));
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    logic signed [CW-1:0] xa, ya, za;
    logic fa;
    if (i == 0) begin : g_in
      assign xa = CORDIC_GAIN;
      assign ya = '0;
      assign za = z0;
      assign fa = fl;
    end else begin : g_mid
      assign xa = x[i-1];
      assign ya = y[i-1];
      assign za = z[i-1];
      assign fa = flip[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!za[CW-1]) begin
          x[i] <= xa - (ya >>> i);
          y[i] <= ya + (xa >>> i);
          z[i] <= za - atan_phase(5'(i));
        end else begin
          x[i] <= xa + (ya >>> i);
          y[i] <= ya - (xa >>> i);
          z[i] <= za + atan_phase(5'(i));
        end
        flip[i] <= fa;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= flip[CORDIC_STAGES-1] ? -y[CORDIC_STAGES-1] : y[CORDIC_STAGES-1];
      cos_o <= flip[CORDIC_STAGES-1] ? -x[CORDIC_STAGES-1] : x[CORDIC_STAGES-1];
    end
  end
endmodule

>>> src/exr_merge.sv
// Merging stage: forms the nine matrix elements from the three lanes' results.
// Depends on exr_pkg; three register stages: two multiplier levels, then sums and rounding.
module exr_merge (
  input  logic clk,
  input  logic en,
  input  logic signed [exr_pkg::CW-1:0] sx, cx, sy, cy, sz, cz,
  output logic signed [exr_pkg::OUT_W-1:0] m [9]
);
  import exr_pkg::*;
  logic signed [CW-1:0] sxsy, cxsy, sx1, cx1, sy1, cy1, sz1, cz1;
  logic signed [CW-1:0] p [13];
  logic signed [CW-1:0] sy2;

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy <= mul30(sx, sy);
      cxsy <= mul30(cx, sy);
      sx1 <= sx; cx1 <= cx; sy1 <= sy; cy1 <= cy; sz1 <= sz; cz1 <= cz;
      p[0] <= mul30(cy1, cz1);
      p[1] <= mul30(cy1, sz1);
      p[2] <= mul30(sxsy, cz1);
      p[3] <= mul30(cx1, sz1);
      p[4] <= mul30(cx1, cz1);
      p[5] <= mul30(sxsy, sz1);
      p[6] <= mul30(sx1, cy1);
      p[7] <= mul30(sx1, sz1);
      p[8] <= mul30(cxsy, cz1);
      p[9] <= mul30(cxsy, sz1);
      p[10] <= mul30(sx1, cz1);
      p[11] <= mul30(cx1, cy1);
      p[12] <= '0;
      sy2 <= sy1;
      m[0] <= to_q15((CW+2)'(p[0]));
      m[1] <= to_q15(-(CW+2)'(p[1]));
      m[2] <= to_q15((CW+2)'(sy2));
      m[3] <= to_q15((CW+2)'(p[2]) + (CW+2)'(p[3]));
      m[4] <= to_q15((CW+2)'(p[4]) - (CW+2)'(p[5]));
      m[5] <= to_q15(-(CW+2)'(p[6]));
      m[6] <= to_q15((CW+2)'(p[7]) - (CW+2)'(p[8]));
      m[7] <= to_q15((CW+2)'(p[9]) + (CW+2)'(p[10]) + (CW+2)'(p[12]));
      m[8] <= to_q15((CW+2)'(p[11]));
    end
  end
endmodule
